### sv/hcc_pkg.sv
// hcc_pkg: payload structs and fixed constants for hamming_cluster_counter.
// No dependencies.
package hcc_pkg;
  localparam int unsigned MAX_NODES = 1024;
  localparam int unsigned NODE_WIDTH = 24;
  localparam int unsigned LINK_DIST = 2;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [23:0] node_bits;
  } in_item_t;

  typedef struct packed {
    logic [10:0] cluster_count;
    logic        overflow;
  } out_item_t;
endpackage

### sv/hamming_cluster_counter.sv
// hamming_cluster_counter: top level, load/compute sequencer over node and parent stores.
// Depends on hcc_pkg, hcc_node_mem, hcc_parent_mem.
//
// Usage: items arrive on in_valid/in_ready carrying hcc_pkg::in_item_t.
// A load item (cmd 0) writes one node vector; loads may transfer back to back.
// A load with the store full is dropped and flagged.
// A compute item (cmd 1) walks every pair (i, j), i < j, of the loaded nodes.
// Before that, every loaded node's parent is set to itself. Node i is latched
// once per row (read, latch); each j is read, compared and advanced past, and,
// when the XOR popcount is 2 or less, two find-root walks go through the parent
// store, each node visited by a read and a check, then a link write when the
// roots differ. An empty store skips the walk and reports in the cycle after
// the compute transfer.
// The result (hcc_pkg::out_item_t) waits in an output register until the
// receiver takes it; a stalled receiver holds the block in its report state,
// and loads are not accepted until the result transfers.
// Reset (rst, synchronous) empties the node count and clears the drop flag;
// memory contents are left as they are and never used before written.
module hamming_cluster_counter (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  hcc_pkg::in_item_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output hcc_pkg::out_item_t out_data
);
  localparam int unsigned AW = (hcc_pkg::MAX_NODES > 1) ? $clog2(hcc_pkg::MAX_NODES) : 1;
  localparam int unsigned CW = $clog2(hcc_pkg::MAX_NODES + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INIT   = 4'd1;
  localparam logic [3:0] S_RDI    = 4'd2;
  localparam logic [3:0] S_LATI   = 4'd3;
  localparam logic [3:0] S_RDJ    = 4'd4;
  localparam logic [3:0] S_CMP    = 4'd5;
  localparam logic [3:0] S_FIND   = 4'd6;
  localparam logic [3:0] S_FWAIT  = 4'd7;
  localparam logic [3:0] S_LINK   = 4'd8;
  localparam logic [3:0] S_NEXT   = 4'd9;
  localparam logic [3:0] S_REPORT = 4'd10;

  logic [3:0]                     state;
  logic [CW-1:0]                  node_count;
  logic                           dropped;
  logic [CW-1:0]                  n;
  logic [CW-1:0]                  i_idx;
  logic [CW-1:0]                  j_idx;
  logic [CW-1:0]                  clusters;
  logic [hcc_pkg::NODE_WIDTH-1:0] node_i;
  logic [AW-1:0]                  cur;       // node being walked toward its root
  logic                           second;    // 0: walking i, 1: walking j
  logic [AW-1:0]                  root_i;

  logic                           nw_en;
  logic [AW-1:0]                  nw_addr;
  logic [AW-1:0]                  nr_addr;
  logic [hcc_pkg::NODE_WIDTH-1:0] nr_data;
  logic                           pw_en;
  logic [AW-1:0]                  pw_addr;
  logic [AW-1:0]                  pw_data;
  logic [AW-1:0]                  pr_addr;
  logic [AW-1:0]                  pr_data;

  logic                           load_xfer;
  logic [hcc_pkg::NODE_WIDTH-1:0] diff;
  logic [hcc_pkg::NODE_WIDTH-1:0] diff1;
  logic [hcc_pkg::NODE_WIDTH-1:0] diff2;
  logic                           near;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_REPORT);
  assign load_xfer = in_valid && in_ready && (in_data.cmd == hcc_pkg::CMD_LOAD);

  // Clear the two lowest set bits; zero left means distance 2 or less.
  assign diff  = nr_data ^ node_i;
  assign diff1 = diff & (diff - 1'b1);
  assign diff2 = diff1 & (diff1 - 1'b1);
  assign near  = (diff2 == '0);

  assign nw_en   = load_xfer && (node_count < CW'(hcc_pkg::MAX_NODES));
  assign nw_addr = node_count[AW-1:0];
  assign nr_addr = (state == S_RDI) ? i_idx[AW-1:0] : j_idx[AW-1:0];

  // Parent port: init writes identity, link writes the larger root's parent.
  always_comb begin
    pw_en   = 1'b0;
    pw_addr = i_idx[AW-1:0];
    pw_data = i_idx[AW-1:0];
    if (state == S_INIT) begin
      pw_en = 1'b1;
    end else if (state == S_LINK && root_i != cur) begin
      pw_en = 1'b1;
      if (root_i < cur) begin
        pw_addr = cur;
        pw_data = root_i;
      end else begin
        pw_addr = root_i;
        pw_data = cur;
      end
    end
  end
  assign pr_addr = cur;

  hcc_node_mem #(.DEPTH(hcc_pkg::MAX_NODES), .WIDTH(hcc_pkg::NODE_WIDTH), .AW(AW)) u_nodes (
    .clk(clk), .wr_en(nw_en), .wr_addr(nw_addr),
    .wr_data(in_data.node_bits[hcc_pkg::NODE_WIDTH-1:0]),
    .rd_addr(nr_addr), .rd_data(nr_data)
  );

  hcc_parent_mem #(.DEPTH(hcc_pkg::MAX_NODES), .AW(AW)) u_parents (
    .clk(clk), .wr_en(pw_en), .wr_addr(pw_addr), .wr_data(pw_data),
    .rd_addr(pr_addr), .rd_data(pr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_count <= '0;
      dropped    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.cmd == hcc_pkg::CMD_LOAD) begin
              if (node_count < CW'(hcc_pkg::MAX_NODES)) begin
                node_count <= node_count + 1'b1;
              end else begin
                dropped <= 1'b1;
              end
            end else begin
              n        <= node_count;
              clusters <= node_count;
              i_idx    <= '0;
              state    <= (node_count == '0) ? S_REPORT : S_INIT;
            end
          end
        end
        S_INIT: begin
          // Point every loaded node at itself, one per cycle.
          if (i_idx == n - 1'b1) begin
            i_idx <= '0;
            state <= S_RDI;
          end else begin
            i_idx <= i_idx + 1'b1;
          end
        end
        S_RDI: begin
          if (i_idx + 1'b1 >= n) begin
            state <= S_REPORT;
          end else begin
            j_idx <= i_idx + 1'b1;
            state <= S_LATI;
          end
        end
        S_LATI: begin
          node_i <= nr_data;
          state  <= S_RDJ;
        end
        S_RDJ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (near) begin
            cur    <= i_idx[AW-1:0];
            second <= 1'b0;
            state  <= S_FWAIT;
          end else begin
            state <= S_NEXT;
          end
        end
        S_FWAIT: begin
          state <= S_FIND;   // parent read in flight
        end
        S_FIND: begin
          if (pr_data == cur) begin
            if (!second) begin
              root_i <= cur;
              cur    <= j_idx[AW-1:0];
              second <= 1'b1;
              state  <= S_FWAIT;
            end else begin
              state <= S_LINK;
            end
          end else begin
            cur   <= pr_data;
            state <= S_FWAIT;
          end
        end
        S_LINK: begin
          if (root_i != cur) begin
            clusters <= clusters - 1'b1;
          end
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (j_idx + 1'b1 >= n) begin
            i_idx <= i_idx + 1'b1;
            state <= S_RDI;
          end else begin
            j_idx <= j_idx + 1'b1;
            state <= S_RDJ;
          end
        end
        S_REPORT: begin
          // Hold the result until the receiver takes it, then empty the store.
          if (out_ready) begin
            node_count <= '0;
            dropped    <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign out_data.cluster_count = 11'(clusters);
  assign out_data.overflow      = dropped;
endmodule

### sv/hcc_node_mem.sv
// hcc_node_mem: node vector store, one write port and one registered read port.
// Depends on nothing.
module hcc_node_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 24,
  parameter int unsigned AW = 10
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

### sv/hcc_parent_mem.sv
// hcc_parent_mem: union-find parent store, one write port and one registered read.
// Depends on nothing.
module hcc_parent_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [AW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [AW-1:0] rd_data
);
  logic [AW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

### sv/hcc_checker.sv
// hcc_checker: port-level assertions for hamming_cluster_counter, bound to the top.
// Depends on hcc_pkg.
module hcc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input hcc_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input hcc_pkg::out_item_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_no_input_while_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");

  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.cmd == hcc_pkg::CMD_COMPUTE |=> !in_ready)
    else $error("ready after compute transfer");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.cmd == hcc_pkg::CMD_LOAD |=> !out_valid)
    else $error("result after load");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.cluster_count <= 11'd1024)
    else $error("cluster count out of range");
endmodule

bind hamming_cluster_counter hcc_checker u_hcc_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
  .out_data(out_data)
);
